>>> rtl/core/rgb2yuv_pkg.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types, register codes and color matrix helper for the RGB to
// YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

	// Register port and field widths
	localparam int CFG_W        = 13;
	localparam int LUMA_IDX_W   = 24;
	localparam int CHROMA_IDX_W = 22;
	localparam int SAMPLE_W     = 8;

	// Register indexes
	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Matrix coefficients (BT.601 studio range, 8-bit fraction)
	typedef logic signed [8:0] coef_t;

	localparam coef_t Y_R = 9'sd66;
	localparam coef_t Y_G = 9'sd129;
	localparam coef_t Y_B = 9'sd25;
	localparam coef_t U_R = -9'sd38;
	localparam coef_t U_G = -9'sd74;
	localparam coef_t U_B = 9'sd112;
	localparam coef_t V_R = 9'sd112;
	localparam coef_t V_G = -9'sd94;
	localparam coef_t V_B = -9'sd18;

	localparam logic [SAMPLE_W-1:0] LUMA_OFFSET   = 8'd16;
	localparam logic [SAMPLE_W-1:0] CHROMA_OFFSET = 8'd128;

	typedef struct packed {
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} pixel_t;

	// Position info of one pixel, taken from the raster counters
	typedef struct packed {
		logic [LUMA_IDX_W-1:0]   luma_index;
		logic                    chroma_valid;
		logic [CHROMA_IDX_W-1:0] chroma_index;
		logic                    frame_end;
	} raster_pos_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]     luma;
		logic [LUMA_IDX_W-1:0]   luma_index;
		logic                    chroma_valid;
		logic [SAMPLE_W-1:0]     chroma_blue;
		logic [SAMPLE_W-1:0]     chroma_red;
		logic [CHROMA_IDX_W-1:0] chroma_index;
		logic                    frame_end;
	} result_t;

	// Weighted sum with rounding, floor shift by 8, plus offset (mod 256)
	function automatic logic [SAMPLE_W-1:0] weigh(
		input logic [SAMPLE_W-1:0] r,
		input logic [SAMPLE_W-1:0] g,
		input logic [SAMPLE_W-1:0] b,
		input coef_t               cr,
		input coef_t               cg,
		input coef_t               cb,
		input logic [SAMPLE_W-1:0] offset
	);
		logic signed [17:0] r_e;
		logic signed [17:0] g_e;
		logic signed [17:0] b_e;
		logic signed [17:0] sum;
		r_e = $signed({10'd0, r});
		g_e = $signed({10'd0, g});
		b_e = $signed({10'd0, b});
		sum = 18'(cr) * r_e + 18'(cg) * g_e + 18'(cb) * b_e + 18'sd128;
		return sum[15:8] + offset;
	endfunction

endpackage

>>> rtl/core/rgb2yuv_raster.sv
// ----------------------------------------------------------------------------
// rgb2yuv_raster
// Column, row and plane position counters for the pixel stream. Gives the
// position of the current pixel and advances on each accepted word.
// ----------------------------------------------------------------------------
module rgb2yuv_raster
	import rgb2yuv_pkg::*;
#(
	parameter int CNT_W = 12,
	parameter int DIM_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] width,
	input  logic [DIM_W-1:0] height,
	input  logic             advance,
	output raster_pos_t      pos
);

	logic [CNT_W-1:0]        col_q;
	logic [CNT_W-1:0]        row_q;
	logic [LUMA_IDX_W-1:0]   luma_q;
	logic [CHROMA_IDX_W-1:0] chroma_q;

	logic line_end;
	logic frame_last;
	logic chroma;

	// Decode line and frame end against the current dimensions
	always_comb begin
		chroma     = !col_q[0] && !row_q[0];
		line_end   = (DIM_W'(col_q) + DIM_W'(1)) >= width;
		frame_last = line_end && ((DIM_W'(row_q) + DIM_W'(1)) >= height);

		pos.luma_index   = luma_q;
		pos.chroma_valid = chroma;
		pos.chroma_index = chroma ? chroma_q : '0;
		pos.frame_end    = frame_last;
	end

	// Advance counters, clear at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			luma_q   <= '0;
			chroma_q <= '0;
		end else if (advance) begin
			if (frame_last) begin
				col_q    <= '0;
				row_q    <= '0;
				luma_q   <= '0;
				chroma_q <= '0;
			end else begin
				luma_q <= luma_q + LUMA_IDX_W'(1);
				if (chroma) begin
					chroma_q <= chroma_q + CHROMA_IDX_W'(1);
				end
				if (line_end) begin
					col_q <= '0;
					row_q <= row_q + CNT_W'(1);
				end else begin
					col_q <= col_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

>>> rtl/core/rgb2yuv_matrix.sv
// ----------------------------------------------------------------------------
// rgb2yuv_matrix
// BT.601 color matrix: forms Y for every pixel and U, V on chroma sites,
// and merges them with the pixel's plane positions into one result word.
// ----------------------------------------------------------------------------
module rgb2yuv_matrix
	import rgb2yuv_pkg::*;
(
	input  pixel_t      pixel,
	input  raster_pos_t pos,
	output result_t     result
);

	logic [SAMPLE_W-1:0] u_raw;
	logic [SAMPLE_W-1:0] v_raw;

	// Compute samples; zero chroma off the chroma sites
	always_comb begin
		u_raw = weigh(pixel.red, pixel.green, pixel.blue, U_R, U_G, U_B, CHROMA_OFFSET);
		v_raw = weigh(pixel.red, pixel.green, pixel.blue, V_R, V_G, V_B, CHROMA_OFFSET);

		result.luma         = weigh(pixel.red, pixel.green, pixel.blue,
		                            Y_R, Y_G, Y_B, LUMA_OFFSET);
		result.luma_index   = pos.luma_index;
		result.chroma_valid = pos.chroma_valid;
		result.chroma_blue  = pos.chroma_valid ? u_raw : '0;
		result.chroma_red   = pos.chroma_valid ? v_raw : '0;
		result.chroma_index = pos.chroma_index;
		result.frame_end    = pos.frame_end;
	end

endmodule

>>> rtl/core/rgb_to_yuv420_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// Streaming RGB24 to YUV 4:2:0 converter, BT.601 studio range.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock in raster order, unless result_ready holds it
// off, and returns one result word per pixel: Y with its luma plane index, and
// on even row and even column also U and V (from the top-left pixel of each
// 2x2 block) with their chroma plane index; frame_end marks the last pixel of
// the frame. Each pixel passes an input register, then a result register
// behind the color matrix; throughput is one pixel per clock with no bubbles
// while result_ready stays high. frame_width and frame_height are saturated to
// 2..MAX_DIMENSION and rounded down to even when written; write them only
// while the block is idle.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter
	import rgb2yuv_pkg::*;
#(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_write,
	input  logic [0:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,

	input  logic                    pixel_valid,
	output logic                    pixel_ready,
	input  logic [SAMPLE_W-1:0]     red,
	input  logic [SAMPLE_W-1:0]     green,
	input  logic [SAMPLE_W-1:0]     blue,

	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [SAMPLE_W-1:0]     luma,
	output logic [LUMA_IDX_W-1:0]   luma_index,
	output logic                    chroma_valid,
	output logic [SAMPLE_W-1:0]     chroma_blue,
	output logic [SAMPLE_W-1:0]     chroma_red,
	output logic [CHROMA_IDX_W-1:0] chroma_index,
	output logic                    frame_end
);

	localparam int CNT_W = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam logic [CFG_W-1:0] DIM_RESET = 13'd256;

	// Saturate a written dimension to 2..MAX_DIMENSION, then round to even
	function automatic logic [DIM_W-1:0] effective_dim(input logic [CFG_W-1:0] raw);
		logic [CMP_W-1:0] d;
		d = CMP_W'(raw);
		if (d < CMP_W'(2)) begin
			d = CMP_W'(2);
		end
		if (d > CMP_W'(MAX_DIMENSION)) begin
			d = CMP_W'(MAX_DIMENSION);
		end
		d[0] = 1'b0;
		return DIM_W'(d);
	endfunction

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	logic        pixel_accept;
	logic        ready_s2;
	logic        valid_s1;
	pixel_t      pixel_s1;
	raster_pos_t pos_s1;
	raster_pos_t pos_cur;
	result_t     result_c;
	logic        valid_s2;
	result_t     result_s2;

	// Hold effective dimensions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= effective_dim(DIM_RESET);
			height_q <= effective_dim(DIM_RESET);
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= effective_dim(cfg_data);
				REG_FRAME_HEIGHT: height_q <= effective_dim(cfg_data);
			endcase
		end
	end

	// Pipeline flow control
	assign ready_s2     = !valid_s2 || result_ready;
	assign pixel_ready  = !valid_s1 || ready_s2;
	assign pixel_accept = pixel_valid && pixel_ready;

	rgb2yuv_raster #(
		.CNT_W (CNT_W),
		.DIM_W (DIM_W)
	) u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.width   (width_q),
		.height  (height_q),
		.advance (pixel_accept),
		.pos     (pos_cur)
	);

	// Stage 1: capture pixel and its position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_accept) begin
			pixel_s1 <= '{red: red, green: green, blue: blue};
			pos_s1   <= pos_cur;
		end
	end

	rgb2yuv_matrix u_matrix (
		.pixel  (pixel_s1),
		.pos    (pos_s1),
		.result (result_c)
	);

	// Stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			result_s2 <= result_c;
		end
	end

	// Drive result ports
	assign result_valid = valid_s2;
	assign luma         = result_s2.luma;
	assign luma_index   = result_s2.luma_index;
	assign chroma_valid = result_s2.chroma_valid;
	assign chroma_blue  = result_s2.chroma_blue;
	assign chroma_red   = result_s2.chroma_red;
	assign chroma_index = result_s2.chroma_index;
	assign frame_end    = result_s2.frame_end;

endmodule

>>> tb/tb_rgb_to_yuv420_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_yuv420_converter
// Self-checking testbench for the streaming RGB to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
// A queue of pixels feeds a valid/ready driver. Each accepted pixel is run
// through a local raster and color matrix predictor, and the predicted result
// word is checked field by field against the output stream. Frame sizes are
// changed between phases, only with the pipeline empty, and cover the
// smallest and largest sizes, out of range and odd values, and shrinking a
// frame while a line or frame is partly done. Both sides idle in random
// bursts, except in the closing phase.
// ----------------------------------------------------------------------------
module tb_rgb_to_yuv420_converter;
	timeunit 1ns;
	timeprecision 1ps;

	import rgb2yuv_pkg::*;

	localparam int MAX_DIM        = 4096;
	localparam int RANDOM_PIXELS  = 1150;
	localparam int WATCHDOG_LIMIT = 2000;

	// BT.601 studio range matrix, 8-bit fraction
	localparam int KY_R = 66;
	localparam int KY_G = 129;
	localparam int KY_B = 25;
	localparam int KU_R = -38;
	localparam int KU_G = -74;
	localparam int KU_B = 112;
	localparam int KV_R = 112;
	localparam int KV_G = -94;
	localparam int KV_B = -18;
	localparam int Y_OFS = 16;
	localparam int C_OFS = 128;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write = 1'b0;
	logic [0:0]              cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    pixel_valid = 1'b0;
	logic                    pixel_ready;
	logic [SAMPLE_W-1:0]     red = '0;
	logic [SAMPLE_W-1:0]     green = '0;
	logic [SAMPLE_W-1:0]     blue = '0;
	logic                    result_valid;
	logic                    result_ready = 1'b0;
	logic [SAMPLE_W-1:0]     luma;
	logic [LUMA_IDX_W-1:0]   luma_index;
	logic                    chroma_valid;
	logic [SAMPLE_W-1:0]     chroma_blue;
	logic [SAMPLE_W-1:0]     chroma_red;
	logic [CHROMA_IDX_W-1:0] chroma_index;
	logic                    frame_end;

	rgb_to_yuv420_converter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.luma         (luma),
		.luma_index   (luma_index),
		.chroma_valid (chroma_valid),
		.chroma_blue  (chroma_blue),
		.chroma_red   (chroma_red),
		.chroma_index (chroma_index),
		.frame_end    (frame_end)
	);

	// Predictor copy of the registers and raster counters
	logic [CFG_W-1:0]        width_reg = 13'd256;
	logic [CFG_W-1:0]        height_reg = 13'd256;
	logic [11:0]             col_pos = '0;
	logic [11:0]             row_pos = '0;
	logic [LUMA_IDX_W-1:0]   luma_pos = '0;
	logic [CHROMA_IDX_W-1:0] chroma_pos = '0;

	pixel_t  pixel_queue[$];
	result_t pending_results[$];

	int pixels_queued = 0;
	int pixels_sent   = 0;
	int frames_seen   = 0;
	int chroma_seen   = 0;
	int settings_used = 0;
	int error_count   = 0;
	int stuck_cycles  = 0;

	// Idle controls, changed per phase
	int  send_gap_pct   = 0;
	int  recv_stall_pct = 0;
	bit  quiet          = 1'b0;
	int  send_gap       = 0;
	int  recv_stall     = 0;

	// Clamp a dimension register to 2..MAX_DIM and round down to even
	function automatic logic [CFG_W-1:0] usable_dim(input logic [CFG_W-1:0] raw);
		logic [CFG_W-1:0] d;
		d = raw;
		if (d < 13'd2)
			d = 13'd2;
		if (d > 13'(MAX_DIM))
			d = 13'(MAX_DIM);
		d[0] = 1'b0;
		return d;
	endfunction

	// Weighted sum, round, floor shift by 8, add offset mod 256
	function automatic logic [7:0] matrix_row(input pixel_t px, input int kr, input int kg,
			input int kb, input int ofs);
		int acc;
		acc = kr * int'(px.red) + kg * int'(px.green) + kb * int'(px.blue) + 128;
		return 8'((acc >>> 8) + ofs);
	endfunction

	// Predict the result word of one pixel and advance the raster position
	function automatic result_t convert_pixel(input pixel_t px);
		result_t          res;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic             at_chroma;
		logic             last_col;
		logic             last_pixel;
		w = usable_dim(width_reg);
		h = usable_dim(height_reg);
		at_chroma  = !col_pos[0] && !row_pos[0];
		last_col   = (13'(col_pos) + 13'd1) >= w;
		last_pixel = last_col && ((13'(row_pos) + 13'd1) >= h);

		res.luma         = matrix_row(px, KY_R, KY_G, KY_B, Y_OFS);
		res.luma_index   = luma_pos;
		res.chroma_valid = at_chroma;
		res.chroma_blue  = at_chroma ? matrix_row(px, KU_R, KU_G, KU_B, C_OFS) : 8'd0;
		res.chroma_red   = at_chroma ? matrix_row(px, KV_R, KV_G, KV_B, C_OFS) : 8'd0;
		res.chroma_index = at_chroma ? chroma_pos : '0;
		res.frame_end    = last_pixel;

		if (last_pixel) begin
			col_pos    = '0;
			row_pos    = '0;
			luma_pos   = '0;
			chroma_pos = '0;
		end else begin
			luma_pos = luma_pos + LUMA_IDX_W'(1);
			if (at_chroma)
				chroma_pos = chroma_pos + CHROMA_IDX_W'(1);
			if (last_col) begin
				col_pos = '0;
				row_pos = row_pos + 12'd1;
			end else begin
				col_pos = col_pos + 12'd1;
			end
		end
		return res;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			error_count++;
		end
	endtask

	// Write one dimension register; the pipeline is empty when this is called
	task automatic write_dim(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_reg = value;
		else
			height_reg = value;
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_dim(REG_FRAME_WIDTH, w);
		write_dim(REG_FRAME_HEIGHT, h);
		settings_used++;
	endtask

	task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		pixel_queue.push_back({r, g, b});
		pixels_queued++;
	endtask

	task automatic add_random_pixels(input int count);
		logic [23:0] raw;
		for (int i = 0; i < count; i++) begin
			raw = 24'($urandom);
			// Every eighth pixel or so, push components to 0 or 255
			if ($urandom_range(7) == 0)
				raw = {{8{raw[0]}}, {8{raw[1]}}, {8{raw[2]}}};
			add_pixel(raw[23:16], raw[15:8], raw[7:0]);
		end
	endtask

	// Hold off until every queued pixel is sent and every result has come
	task automatic wait_drained();
		while (pixels_sent != pixels_queued || pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_pct();
		case ($urandom_range(3))
			0: return 0;
			1: return 10;
			2: return 35;
			default: return 70;
		endcase
	endfunction

	initial begin
		forever #1 clk = ~clk;
	end

	// Pixel driver: present the next queued word, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		pixel_t px;
		logic   next_valid;
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			send_gap    <= 0;
		end else begin
			next_valid = pixel_valid;
			if (pixel_valid && pixel_ready) begin
				pending_results.push_back(convert_pixel({red, green, blue}));
				pixels_sent++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
				end else if (!quiet && send_gap_pct != 0 &&
						$urandom_range(99) < send_gap_pct) begin
					send_gap <= $urandom_range(1, 11);
				end else if (pixel_queue.size() != 0) begin
					px = pixel_queue.pop_front();
					red   <= px.red;
					green <= px.green;
					blue  <= px.blue;
					next_valid = 1'b1;
				end
			end
			pixel_valid <= next_valid;
		end
	end

	// Result monitor: check each accepted word, stall ready in bursts
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_stall   <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					$error("result word with no pixel pending, luma_index %0d", luma_index);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("luma", 32'(want.luma), 32'(luma));
					check_field("luma_index", 32'(want.luma_index), 32'(luma_index));
					check_field("chroma_valid", 32'(want.chroma_valid), 32'(chroma_valid));
					check_field("chroma_blue", 32'(want.chroma_blue), 32'(chroma_blue));
					check_field("chroma_red", 32'(want.chroma_red), 32'(chroma_red));
					check_field("chroma_index", 32'(want.chroma_index), 32'(chroma_index));
					check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
				end
				if (frame_end === 1'b1)
					frames_seen++;
				if (chroma_valid === 1'b1)
					chroma_seen++;
			end
			if (recv_stall != 0) begin
				recv_stall   <= recv_stall - 1;
				result_ready <= 1'b0;
			end else if (!quiet && recv_stall_pct != 0 &&
					$urandom_range(99) < recv_stall_pct) begin
				recv_stall   <= $urandom_range(1, 11);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$error("no word accepted for %0d cycles", stuck_cycles);
			$display("FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		int target;
		int count;
		int phase_no;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame: primaries, black, white, two full 2x2 frames
		send_gap_pct   = 20;
		recv_stall_pct = 20;
		set_frame(13'd2, 13'd2);
		add_pixel(8'd0, 8'd0, 8'd255);
		add_pixel(8'd0, 8'd0, 8'd0);
		add_pixel(8'd255, 8'd255, 8'd255);
		add_pixel(8'd0, 8'd255, 8'd0);
		add_pixel(8'd255, 8'd0, 8'd0);
		add_pixel(8'd0, 8'd255, 8'd255);
		add_pixel(8'd255, 8'd0, 8'd255);
		add_pixel(8'd255, 8'd255, 8'd0);
		wait_drained();

		// Below range: zero width and height one both act as two
		set_frame(13'd0, 13'd1);
		add_pixel(8'd0, 8'd255, 8'd0);
		add_pixel(8'd255, 8'd255, 8'd255);
		add_pixel(8'd0, 8'd0, 8'd0);
		add_pixel(8'd255, 8'd0, 8'd0);
		wait_drained();

		// Above range width, odd height
		set_frame(13'h1FFF, 13'd3);
		add_random_pixels(6);
		wait_drained();

		// Shrink width mid-line so the column is already past the last one
		write_dim(REG_FRAME_WIDTH, 13'd3);
		settings_used++;
		add_random_pixels(4);
		wait_drained();

		// Random phases; the sender holds off between phases until drained
		target   = pixels_queued + RANDOM_PIXELS;
		phase_no = 0;
		while (pixels_queued < target) begin
			send_gap_pct   = pick_pct();
			recv_stall_pct = pick_pct();
			count = $urandom_range(40, 120);
			case (phase_no)
				0: begin
					set_frame(13'd4097, 13'd2);
					count = 150;
				end
				1: begin
					set_frame(13'd2, 13'd4096);
					count = 150;
				end
				2: begin
					// Shrink height while the row is far past the new last row
					write_dim(REG_FRAME_HEIGHT, 13'd4);
					settings_used++;
				end
				default: begin
					case ($urandom_range(7))
						0, 1, 2, 3:
							set_frame(13'(2 * $urandom_range(1, 8)),
								13'(2 * $urandom_range(1, 4)));
						4: set_frame(13'($urandom_range(0, 31)), 13'($urandom_range(0, 15)));
						5: set_frame(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 9)));
						6: begin
							write_dim(REG_FRAME_HEIGHT, 13'($urandom_range(0, 12)));
							settings_used++;
						end
						default: begin
							write_dim(REG_FRAME_WIDTH, 13'($urandom_range(0, 20)));
							settings_used++;
						end
					endcase
				end
			endcase
			// Run the closing stretch with no idling on either side
			if (target - pixels_queued <= 200) begin
				count = target - pixels_queued;
				quiet = 1'b1;
			end
			add_random_pixels(count);
			wait_drained();
			phase_no++;
		end

		// Let any stray word come out of the pipeline
		repeat (8) @(posedge clk);

		$display("Checked %0d pixels over %0d frame settings.", pixels_sent, settings_used);
		$display("Saw %0d frame ends and %0d chroma samples.", frames_seen, chroma_seen);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/rgb2yuv_pkg.sv
rtl/core/rgb2yuv_raster.sv
rtl/core/rgb2yuv_matrix.sv
rtl/core/rgb_to_yuv420_converter.sv
tb/tb_rgb_to_yuv420_converter.sv
